@@ rtl/core/stl_pkg.sv @@
package stl_pkg;

    localparam int POS_BITS      = 16;
    localparam int KEYWORD_CHARS = 8;
    localparam int WLEN_BITS     = $clog2(KEYWORD_CHARS + 2);
    localparam int WIDX_BITS     = $clog2(KEYWORD_CHARS);
    localparam int NUM_KW        = 12;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR         = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;

    localparam logic [5:0] K_ERROR = 6'd0;
    localparam logic [5:0] K_END   = 6'd1;
    localparam logic [5:0] K_IDENT = 6'd2;
    localparam logic [5:0] K_PUNCT = 6'd3;
    localparam logic [5:0] K_INT   = 6'd23;
    localparam logic [5:0] K_FLOAT = 6'd24;
    localparam logic [5:0] K_STR   = 6'd25;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADCHAR = 2'd1;
    localparam logic [1:0] ST_STRNL   = 2'd2;

    typedef enum logic [10:0] {
        M_INIT   = 11'b000_0000_0001,
        M_INT    = 11'b000_0000_0010,
        M_INTDOT = 11'b000_0000_0100,
        M_FLOAT  = 11'b000_0000_1000,
        M_IDENT  = 11'b000_0001_0000,
        M_STR    = 11'b000_0010_0000,
        M_STRESC = 11'b000_0100_0000,
        M_CCMT   = 11'b000_1000_0000,
        M_LCMT   = 11'b001_0000_0000,
        M_OP     = 11'b010_0000_0000,
        M_HALT   = 11'b100_0000_0000
    } t_mode;

    typedef struct packed {
        logic       sp;
        logic       dig;
        logic       alp;
        logic       numt;
        logic       idt;
        logic       punct;
        logic [5:0] punct_kind;
        logic       op_hit;
        logic [3:0] op_idx;
    } t_cls;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_end;
        t_cls       cls;
    } t_item;

    typedef struct packed {
        logic [5:0]          kind;
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] len;
        logic [31:0]         value;
        logic [15:0]         line;
        logic [1:0]          status;
        logic                last;
    } t_tok;

    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok0;
        t_tok       tok1;
    } t_wr;

    typedef struct packed {
        logic [7:0] c;
        logic [5:0] t1;
        logic [7:0] a;
        logic [5:0] ta;
        logic [7:0] b;
        logic [5:0] tb;
        logic [7:0] c3;
        logic [5:0] t3;
        logic [5:0] pre;
    } t_op;

    typedef struct packed {
        logic [8*KEYWORD_CHARS-1:0] s;
        logic [WLEN_BITS-1:0]       n;
        logic [5:0]                 kind;
    } t_kw;

    function automatic t_op op_row(input logic [3:0] i);
        t_op r;
        r = '0;
        case (i)
            4'd0:  r = '{"=", 6'd26, "=", 6'd56, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd1:  r = '{"+", 6'd27, "+", 6'd34, "=", 6'd36, 8'd0, 6'd0, 6'd0};
            4'd2:  r = '{"-", 6'd28, "-", 6'd35, "=", 6'd37, 8'd0, 6'd0, 6'd0};
            4'd3:  r = '{"*", 6'd29, "=", 6'd38, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd4:  r = '{"/", 6'd30, "=", 6'd39, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd5:  r = '{"%", 6'd31, "=", 6'd40, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd6:  r = '{"^", 6'd32, "=", 6'd41, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd7:  r = '{"$", 6'd33, 8'd0, 6'd0, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd8:  r = '{"&", 6'd42, "&", 6'd53, "=", 6'd48, 8'd0, 6'd0, 6'd0};
            4'd9:  r = '{"|", 6'd43, "|", 6'd54, "=", 6'd49, 8'd0, 6'd0, 6'd0};
            4'd10: r = '{"#", 6'd44, "=", 6'd50, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd11: r = '{"~", 6'd45, 8'd0, 6'd0, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            4'd12: r = '{"<", 6'd58, "<", 6'd46, "=", 6'd60, "=", 6'd51, 6'd46};
            4'd13: r = '{">", 6'd59, ">", 6'd47, "=", 6'd61, "=", 6'd52, 6'd47};
            4'd14: r = '{"!", 6'd55, "=", 6'd57, 8'd0, 6'd0, 8'd0, 6'd0, 6'd0};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_kw kw_row(input logic [3:0] i);
        t_kw r;
        r = '0;
        case (i)
            4'd0:  r = '{64'("var"),      WLEN_BITS'(3), 6'd11};
            4'd1:  r = '{64'("true"),     WLEN_BITS'(4), 6'd12};
            4'd2:  r = '{64'("false"),    WLEN_BITS'(5), 6'd13};
            4'd3:  r = '{64'("if"),       WLEN_BITS'(2), 6'd14};
            4'd4:  r = '{64'("else"),     WLEN_BITS'(4), 6'd15};
            4'd5:  r = '{64'("break"),    WLEN_BITS'(5), 6'd16};
            4'd6:  r = '{64'("continue"), WLEN_BITS'(8), 6'd17};
            4'd7:  r = '{64'("for"),      WLEN_BITS'(3), 6'd18};
            4'd8:  r = '{64'("while"),    WLEN_BITS'(5), 6'd19};
            4'd9:  r = '{64'("func"),     WLEN_BITS'(4), 6'd20};
            4'd10: r = '{64'("return"),   WLEN_BITS'(6), 6'd21};
            4'd11: r = '{64'("host"),     WLEN_BITS'(4), 6'd22};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/stl_front.sv @@
module stl_front
    import stl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [7:0] i_ch,
    input  logic       i_is_end,
    output logic       o_valid,
    output t_item      o_item,
    input  logic       i_take
);

    t_item            r_mem [Q_DEPTH];
    logic [Q_PTR-1:0] r_wp, r_rp;
    logic [Q_PTR:0]   r_cnt;
    t_cls             w_cls;
    logic             w_wr;
    logic             w_rd;

    always_comb begin
        w_cls        = '0;
        w_cls.sp     = (i_ch == 8'h20) || (i_ch inside {[8'd9:8'd13]});
        w_cls.dig    = i_ch inside {["0":"9"]};
        w_cls.alp    = (i_ch inside {["a":"z"], ["A":"Z"]}) || (i_ch == "_");
        w_cls.numt   = w_cls.sp || (i_ch inside {";", ")", "]", ",", "+", "-", "*", "/",
                       "%", "^", "&", "|", "#", "~", "<", ">", "!", "="});
        w_cls.idt    = w_cls.numt || (i_ch inside {"(", "[", "{", "}", "$"});
        w_cls.punct  = 1'b1;
        case (i_ch)
            ";": w_cls.punct_kind = K_PUNCT;
            "(": w_cls.punct_kind = K_PUNCT + 6'd1;
            ")": w_cls.punct_kind = K_PUNCT + 6'd2;
            "[": w_cls.punct_kind = K_PUNCT + 6'd3;
            "]": w_cls.punct_kind = K_PUNCT + 6'd4;
            ",": w_cls.punct_kind = K_PUNCT + 6'd5;
            "{": w_cls.punct_kind = K_PUNCT + 6'd6;
            "}": w_cls.punct_kind = K_PUNCT + 6'd7;
            default: w_cls.punct = 1'b0;
        endcase
        w_cls.op_hit = 1'b0;
        for (int k = 0; k < 15; k++) begin
            if (!w_cls.op_hit && op_row(4'(k)).c == i_ch) begin
                w_cls.op_hit = 1'b1;
                w_cls.op_idx = 4'(k);
            end
        end
    end

    assign o_full  = (r_cnt == (Q_PTR+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= '{i_ch, i_is_end, w_cls};
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_PTR+1)'(w_wr) - (Q_PTR+1)'(w_rd);
        end
    end

endmodule

@@ rtl/core/stl_back.sv @@
module stl_back
    import stl_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_item i_item,
    output t_wr   o_wr
);

    t_mode                 r_mode, n_mode;
    logic [3:0]            r_pidx, n_pidx;
    logic [5:0]            r_pkind, n_pkind;
    logic                  r_star, n_star;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [POS_BITS-1:0]   r_tstart, n_tstart;
    logic [15:0]           r_line, n_line;
    logic [31:0]           r_acc, n_acc;
    logic [7:0]            r_word [KEYWORD_CHARS];
    logic                  n_wwe;
    logic [WIDX_BITS-1:0]  n_widx;
    logic [WLEN_BITS-1:0]  r_wlen, n_wlen;

    t_tok                  w_toks [2];
    logic [1:0]            w_cnt;
    logic [5:0]            w_wkind;

    function automatic t_tok mk(input logic [5:0] kind, input logic [POS_BITS-1:0] start,
                                input logic [POS_BITS-1:0] len, input logic [31:0] val,
                                input logic [15:0] line, input logic [1:0] status);
        return '{kind, start, len, val, line, status, 1'b0};
    endfunction

    always_comb begin
        t_kw kw;
        logic m;
        w_wkind = K_IDENT;
        for (int k = 0; k < NUM_KW; k++) begin
            kw = kw_row(4'(k));
            m  = (kw.n == r_wlen);
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                if (WLEN_BITS'(j) < kw.n &&
                    r_word[j] != kw.s[(int'(kw.n) - 1 - j) * 8 +: 8]) m = 1'b0;
            end
            if (m) w_wkind = kw.kind;
        end
    end

    always_comb begin
        logic [7:0]          ch;
        t_cls                c;
        logic [15:0]         line_nx;
        logic [POS_BITS-1:0] len;
        logic                do_init;
        logic                hit;
        logic [5:0]          k;
        t_op                 row;

        ch       = i_item.ch;
        c        = i_item.cls;
        n_mode   = r_mode;
        n_pidx   = r_pidx;
        n_pkind  = r_pkind;
        n_star   = r_star;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_line   = r_line;
        n_acc    = r_acc;
        n_wlen   = r_wlen;
        n_wwe    = 1'b0;
        n_widx   = '0;
        w_toks[0] = '0;
        w_toks[1] = '0;
        w_cnt    = '0;
        do_init  = 1'b0;
        hit      = 1'b0;
        k        = '0;
        row      = op_row(r_pidx);
        len      = r_pos - r_tstart;
        line_nx  = r_line;
        if (ch == CH_LF && r_line != 16'hFFFF) line_nx = r_line + 16'd1;

        if (i_take && i_item.is_end) begin
            if (r_mode == M_OP) begin
                w_toks[w_cnt[0]] = mk(r_pkind, r_tstart,
                    (r_pkind != row.t1) ? POS_BITS'(2) : POS_BITS'(1), '0, r_line, ST_OK);
                w_cnt = w_cnt + 2'd1;
            end
            w_toks[w_cnt[0]] = mk(K_END, r_pos, '0, '0, r_line, ST_OK);
            w_cnt    = w_cnt + 2'd1;
            n_mode   = M_INIT;
            n_pidx   = '0;
            n_pkind  = '0;
            n_star   = 1'b0;
            n_pos    = '0;
            n_tstart = '0;
            n_line   = 16'd1;
            n_acc    = '0;
            n_wlen   = '0;
        end else if (i_take && r_mode != M_HALT) begin
            n_line = line_nx;
            n_pos  = r_pos + 1'b1;
            case (r_mode)
                M_INT: begin
                    if (c.dig) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + 32'(ch - CH_ZERO);
                    end else if (ch == CH_DOT) begin
                        n_mode = M_INTDOT;
                    end else if (c.numt) begin
                        w_toks[w_cnt[0]] = mk(K_INT, r_tstart, len, r_acc, line_nx, ST_OK);
                        w_cnt = w_cnt + 2'd1;
                        do_init = 1'b1;
                    end else begin
                        n_mode = M_HALT;
                        w_toks[w_cnt[0]] = mk(K_ERROR, r_pos, '0, '0, line_nx, ST_BADCHAR);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                M_INTDOT: begin
                    if (c.dig) begin
                        n_mode = M_FLOAT;
                    end else begin
                        n_mode = M_HALT;
                        w_toks[w_cnt[0]] = mk(K_ERROR, r_pos, '0, '0, line_nx, ST_BADCHAR);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                M_FLOAT: begin
                    if (c.dig) begin
                        n_mode = M_FLOAT;
                    end else if (c.numt) begin
                        w_toks[w_cnt[0]] = mk(K_FLOAT, r_tstart, len, '0, line_nx, ST_OK);
                        w_cnt = w_cnt + 2'd1;
                        do_init = 1'b1;
                    end else begin
                        n_mode = M_HALT;
                        w_toks[w_cnt[0]] = mk(K_ERROR, r_pos, '0, '0, line_nx, ST_BADCHAR);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                M_IDENT: begin
                    if (c.alp || c.dig) begin
                        if (r_wlen < WLEN_BITS'(KEYWORD_CHARS)) begin
                            n_wwe  = 1'b1;
                            n_widx = r_wlen[WIDX_BITS-1:0];
                        end
                        if (r_wlen <= WLEN_BITS'(KEYWORD_CHARS)) n_wlen = r_wlen + 1'b1;
                    end else if (c.idt) begin
                        w_toks[w_cnt[0]] = mk((r_wlen > WLEN_BITS'(KEYWORD_CHARS)) ?
                            K_IDENT : w_wkind, r_tstart, len, '0, line_nx, ST_OK);
                        w_cnt = w_cnt + 2'd1;
                        do_init = 1'b1;
                    end else begin
                        n_mode = M_HALT;
                        w_toks[w_cnt[0]] = mk(K_ERROR, r_pos, '0, '0, line_nx, ST_BADCHAR);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                M_STR: begin
                    if (ch == CH_BSLASH) begin
                        n_mode = M_STRESC;
                    end else if (ch == CH_LF) begin
                        n_mode = M_HALT;
                        w_toks[w_cnt[0]] = mk(K_ERROR, r_pos, '0, '0, line_nx, ST_STRNL);
                        w_cnt = w_cnt + 2'd1;
                    end else if (ch == CH_QUOTE) begin
                        n_mode = M_INIT;
                        w_toks[w_cnt[0]] = mk(K_STR, r_tstart, len, '0, line_nx, ST_OK);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                M_STRESC: begin
                    if (ch == CH_BSLASH || ch == CH_QUOTE) begin
                        n_mode = M_STR;
                    end else begin
                        n_mode = M_HALT;
                        w_toks[w_cnt[0]] = mk(K_ERROR, r_pos, '0, '0, line_nx, ST_BADCHAR);
                        w_cnt = w_cnt + 2'd1;
                    end
                end
                M_CCMT: begin
                    if (r_star && ch == CH_SLASH) begin
                        n_mode = M_INIT;
                        n_star = 1'b0;
                    end else begin
                        n_star = (ch == CH_STAR);
                    end
                end
                M_LCMT: begin
                    if (ch == CH_LF) n_mode = M_INIT;
                end
                M_OP: begin
                    if (r_pkind == row.t1) begin
                        if (row.c == CH_SLASH && ch == CH_STAR) begin
                            n_mode = M_CCMT;
                            n_star = 1'b0;
                        end else if (row.c == CH_SLASH && ch == CH_SLASH) begin
                            n_mode = M_LCMT;
                        end else if (row.a != '0 && ch == row.a) begin
                            hit = 1'b1;
                            k   = row.ta;
                        end else if (row.b != '0 && ch == row.b) begin
                            hit = 1'b1;
                            k   = row.tb;
                        end else begin
                            w_toks[w_cnt[0]] = mk(row.t1, r_tstart, POS_BITS'(1), '0,
                                                  r_line, ST_OK);
                            w_cnt = w_cnt + 2'd1;
                            do_init = 1'b1;
                        end
                        if (hit) begin
                            if (row.pre != '0 && k == row.pre) begin
                                n_pkind = k;
                            end else begin
                                n_mode = M_INIT;
                                w_toks[w_cnt[0]] = mk(k, r_tstart, POS_BITS'(2), '0,
                                                      line_nx, ST_OK);
                                w_cnt = w_cnt + 2'd1;
                            end
                        end
                    end else if (row.c3 != '0 && ch == row.c3) begin
                        n_mode = M_INIT;
                        w_toks[w_cnt[0]] = mk(row.t3, r_tstart, POS_BITS'(3), '0,
                                              line_nx, ST_OK);
                        w_cnt = w_cnt + 2'd1;
                    end else begin
                        w_toks[w_cnt[0]] = mk(r_pkind, r_tstart, POS_BITS'(2), '0,
                                              r_line, ST_OK);
                        w_cnt = w_cnt + 2'd1;
                        do_init = 1'b1;
                    end
                end
                default: do_init = 1'b1;
            endcase

            if (do_init) begin
                n_mode = M_INIT;
                if (c.sp) begin
                    n_mode = M_INIT;
                end else if (c.dig) begin
                    n_mode   = M_INT;
                    n_tstart = r_pos;
                    n_acc    = 32'(ch - CH_ZERO);
                end else if (c.alp) begin
                    n_mode   = M_IDENT;
                    n_tstart = r_pos;
                    n_wwe    = 1'b1;
                    n_widx   = '0;
                    n_wlen   = WLEN_BITS'(1);
                end else if (ch == CH_QUOTE) begin
                    n_mode   = M_STR;
                    n_tstart = r_pos + 1'b1;
                end else if (c.punct) begin
                    w_toks[w_cnt[0]] = mk(c.punct_kind, r_pos, POS_BITS'(1), '0,
                                          line_nx, ST_OK);
                    w_cnt = w_cnt + 2'd1;
                end else if (c.op_hit) begin
                    if (op_row(c.op_idx).a == '0) begin
                        w_toks[w_cnt[0]] = mk(op_row(c.op_idx).t1, r_pos, POS_BITS'(1),
                                              '0, line_nx, ST_OK);
                        w_cnt = w_cnt + 2'd1;
                    end else begin
                        n_mode   = M_OP;
                        n_pidx   = c.op_idx;
                        n_pkind  = op_row(c.op_idx).t1;
                        n_tstart = r_pos;
                    end
                end else begin
                    n_mode = M_HALT;
                    w_toks[w_cnt[0]] = mk(K_ERROR, r_pos, '0, '0, line_nx, ST_BADCHAR);
                    w_cnt = w_cnt + 2'd1;
                end
            end
        end

        if (w_cnt != '0) w_toks[w_cnt[0] - 1'b1].last = 1'b1;
    end

    assign o_wr = '{w_cnt, w_toks[0], w_toks[1]};

    always_ff @(posedge i_clk) begin
        if (n_wwe) r_word[n_widx] <= i_item.ch;
        r_pidx <= n_pidx;
        r_acc  <= n_acc;
        if (!i_rst_n) begin
            r_mode   <= M_INIT;
            r_pkind  <= '0;
            r_star   <= 1'b0;
            r_pos    <= '0;
            r_tstart <= '0;
            r_line   <= 16'd1;
            r_wlen   <= '0;
        end else begin
            r_mode   <= n_mode;
            r_pkind  <= n_pkind;
            r_star   <= n_star;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_line   <= n_line;
            r_wlen   <= n_wlen;
        end
    end

`ifndef SYNTHESIS
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_item.is_end) |=> (r_mode == M_INIT && r_pos == '0 && r_line == 16'd1))
        else $error("end item did not restore scan state");
    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_item.is_end && r_mode == M_HALT) |-> (o_wr.cnt == 2'd0))
        else $error("token emitted while halted");
    a_halt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_item.is_end && r_mode == M_HALT) |=> $stable(r_pos))
        else $error("position moved while halted");
    a_line_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line != 16'd0)
        else $error("line counter reached zero");
`endif

endmodule

@@ rtl/core/stl_outq.sv @@
module stl_outq
    import stl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_wr  i_wr,
    output logic o_room,
    output logic o_empty,
    input  logic i_pop,
    output t_tok o_tok
);

    t_tok             r_mem [Q_DEPTH];
    logic [Q_PTR-1:0] r_wp, r_rp;
    logic [Q_PTR:0]   r_cnt;
    logic             w_rd;

    assign o_room  = (r_cnt <= (Q_PTR+1)'(Q_DEPTH - 2));
    assign o_empty = (r_cnt == '0);
    assign o_tok   = r_mem[r_rp];
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_wr.cnt != 2'd0) r_mem[r_wp] <= i_wr.tok0;
        if (i_wr.cnt == 2'd2) r_mem[r_wp + 1'b1] <= i_wr.tok1;
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + Q_PTR'(i_wr.cnt);
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (Q_PTR+1)'(i_wr.cnt) - (Q_PTR+1)'(w_rd);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.cnt != 2'd0) |-> o_room)
        else $error("result queue written without room");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (Q_PTR+1)'(Q_DEPTH))
        else $error("result queue count out of range");
    a_wr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.cnt != 2'd3)
        else $error("more than two tokens from one item");
`endif

endmodule

@@ rtl/core/script_token_lexer_top.sv @@
// Streaming tokenizer for a small C-like script language. Source bytes go in
// through a 4-entry input queue, one per push; an item with i_is_end set ends
// the source, flushes a held operator and yields the end token, then all scan
// state returns to reset. Tokens come out of a 4-entry result queue with kind,
// offset, length, int value, line, status and a last flag on the final token
// of each input item. The scanner takes one item per cycle while the result
// queue has room for two tokens, so throughput is one byte per cycle as long
// as the consumer pops at least one token per cycle; a token is visible once
// its completing item has passed the input queue and the result queue. After
// an error token, bytes are dropped until the end marker.
module script_token_lexer_top
    import stl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          i_ch,
    input  logic                i_is_end,
    output logic                empty,
    input  logic                pop,
    output logic [5:0]          o_token_kind,
    output logic [POS_BITS-1:0] o_start_offset,
    output logic [POS_BITS-1:0] o_text_length,
    output logic [31:0]         o_int_value,
    output logic [15:0]         o_line_number,
    output logic [1:0]          o_status,
    output logic                o_last
);

    logic  w_valid;
    logic  w_room;
    logic  w_take;
    t_item w_item;
    t_wr   w_wr;
    t_tok  w_tok;

    assign w_take = w_valid && w_room;

    stl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_ch     (i_ch),
        .i_is_end (i_is_end),
        .o_valid  (w_valid),
        .o_item   (w_item),
        .i_take   (w_take)
    );

    stl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_item  (w_item),
        .o_wr    (w_wr)
    );

    stl_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .o_room  (w_room),
        .o_empty (empty),
        .i_pop   (pop),
        .o_tok   (w_tok)
    );

    assign o_token_kind   = w_tok.kind;
    assign o_start_offset = w_tok.start;
    assign o_text_length  = w_tok.len;
    assign o_int_value    = w_tok.value;
    assign o_line_number  = w_tok.line;
    assign o_status       = w_tok.status;
    assign o_last         = w_tok.last;

endmodule
